// ===== design/lap3_pkg.sv =====
// lap3_pkg: shared types and constants of the 3x3 laplacian edge filter
// no dependencies
`timescale 1ns / 1ps

package lap3_pkg;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // register reset values
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // one beat on its way from the position counters to the window
  typedef struct packed {
    logic             is_pix;
    logic [PIX_W-1:0] pix;
    logic             emit;
    logic             border;
    logic             last;
  } item_t;

  // 3x3 neighborhood, [row][column], row 0 oldest line, column 2 newest pixel
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

endpackage

// ===== design/laplacian_3x3_edge_filter_top.sv =====
// an emitting beat passes stage 1, stage 2 and the output register before out_valid rises
// throughput: one beat per cycle unless out_ready stalls, pixels and flush beats alike; the
//   single line store port pair (one read at acceptance, one write back from stage 1) sets it
// reset: synchronous active-low; positions and pending count clear, frame is 640x480,
//   window clears; line store contents stay undefined, there is no clearing pass
// laplacian_3x3_edge_filter_top: top level, depends on lap3_pkg, lap3_ram, lap3_ctrl, lap3_win
`timescale 1ns / 1ps

module laplacian_3x3_edge_filter_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel / flush beats
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [lap3_pkg::PIX_W-1:0]      in_pixel_in,
  // filtered pixels
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lap3_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                            out_frame_last,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lap3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lap3_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lap3_pkg::*;

  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int ROWW = $clog2(MAX_HEIGHT);

  // registers hold the clamped size minus one, the only form the counters use
  function automatic logic [COLW-1:0] w_last_of(input logic [FW_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v < 3) v = 3;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return COLW'(v - 1);
  endfunction

  function automatic logic [ROWW-1:0] h_last_of(input logic [FH_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v < 3) v = 3;
    if (v > MAX_HEIGHT) v = MAX_HEIGHT;
    return ROWW'(v - 1);
  endfunction

  logic [COLW-1:0] w_last_r;
  logic [ROWW-1:0] h_last_r;
  logic            cfg_wr, restart, accept;

  item_t           item;
  logic [COLW-1:0] col;

  logic                 ram_we;
  logic [COLW-1:0]      ram_waddr;
  logic [2*PIX_W-1:0]   ram_wdata, ram_rdata;

  // the user must write only while idle; the block itself does not enforce it, the port never pushes back
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // any write to a listed register restarts the frame, even with an equal value
  assign restart   = cfg_wr &&
                     (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= w_last_of(FRAME_WIDTH_RST);
      h_last_r <= h_last_of(FRAME_HEIGHT_RST);
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          w_last_r <= w_last_of(cfg_data[FW_W-1:0]);
        end
        CFG_FRAME_HEIGHT: begin
          h_last_r <= h_last_of(cfg_data[FH_W-1:0]);
        end
        default: begin
          // index beyond the register list: no effect
        end
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  // position counters decide at acceptance whether this beat emits and
  // whether the emitted pixel sits on the border
  lap3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .w_last   (w_last_r),
    .h_last   (h_last_r),
    .accept   (accept),
    .req_type (in_req_type),
    .pixel    (in_pixel_in),
    .item     (item),
    .col      (col)
  );

  // both line buffers share one ram entry per column: {upper, middle}
  // read at acceptance, written back when the beat leaves stage 1; the same
  // column comes round again only after at least three pixels, so the write
  // always lands before the next read of that entry
  lap3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // window shift, kernel sums, clamp and the output register; each stage
  // moves on its own so beats that emit nothing keep flowing while a result waits
  lap3_win #(
    .COLW (COLW)
  ) u_win (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (item),
    .col        (col),
    .rdata      (ram_rdata),
    .in_ready   (in_ready),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (out_pixel_out),
    .frame_last (out_frame_last)
  );

endmodule

// ===== design/lap3_ram.sv =====
// lap3_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`timescale 1ns / 1ps

module lap3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lap3_ctrl.sv =====
// lap3_ctrl: input and output position counters, pending count, emit decision
// depends on lap3_pkg
`timescale 1ns / 1ps

module lap3_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic [$clog2(MAX_WIDTH)-1:0]  w_last,
  input  logic [$clog2(MAX_HEIGHT)-1:0] h_last,
  input  logic                          accept,
  input  logic                          req_type,
  input  logic [lap3_pkg::PIX_W-1:0]    pixel,
  output lap3_pkg::item_t               item,
  output logic [$clog2(MAX_WIDTH)-1:0]  col
);

  import lap3_pkg::*;

  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int ROWW = $clog2(MAX_HEIGHT);
  localparam int PW   = $clog2(MAX_WIDTH + 2);

  logic [COLW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROWW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [PW-1:0]   pend_r, pend_nxt;
  logic [PW-1:0]   thr;
  logic            pix_req, emit;

  assign pix_req = (req_type == REQ_PIXEL);
  // emit on a pixel once more than width outputs are pending
  assign thr     = PW'(w_last) + PW'(1);
  assign emit    = pix_req ? (pend_r > thr)
                           : (in_col_r == '0 && in_row_r == '0 && pend_r != '0);

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r;
    if (pix_req) begin
      if (in_col_r == w_last) begin
        in_col_nxt = '0;
        in_row_nxt = (in_row_r == h_last) ? '0 : in_row_r + ROWW'(1);
      end else begin
        in_col_nxt = in_col_r + COLW'(1);
      end
      if (!emit) begin
        pend_nxt = pend_r + PW'(1);
      end
    end else if (emit) begin
      pend_nxt = pend_r - PW'(1);
    end
    if (emit) begin
      if (out_col_r == w_last) begin
        out_col_nxt = '0;
        out_row_nxt = (out_row_r == h_last) ? '0 : out_row_r + ROWW'(1);
      end else begin
        out_col_nxt = out_col_r + COLW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else if (accept) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_comb begin
    item.is_pix = pix_req;
    item.pix    = pixel;
    item.emit   = emit;
    item.border = (out_row_r == '0) || (out_row_r == h_last) ||
                  (out_col_r == '0) || (out_col_r == w_last);
    item.last   = (out_row_r == h_last) && (out_col_r == w_last);
  end

  assign col = in_col_r;

endmodule

// ===== design/lap3_win.sv =====
// lap3_win: line store write-back, 3x3 window, kernel pipeline and output register
// depends on lap3_pkg
`timescale 1ns / 1ps

module lap3_win #(
  parameter int COLW = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  lap3_pkg::item_t              item,
  input  logic [COLW-1:0]              col,
  input  logic [2*lap3_pkg::PIX_W-1:0] rdata,
  output logic                         in_ready,
  output logic                         ram_we,
  output logic [COLW-1:0]              ram_waddr,
  output logic [2*lap3_pkg::PIX_W-1:0] ram_wdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lap3_pkg::PIX_W-1:0]   pixel_out,
  output logic                         frame_last
);

  import lap3_pkg::*;

  // stage 1: line store data arrives
  logic            s1_valid_r;
  item_t           s1_item_r;
  logic [COLW-1:0] s1_col_r;
  window_t         win_r, win_nxt;
  logic [PIX_W-1:0] top, mid;

  // stage 2: partial sums
  logic            s2_valid_r, s2_border_r, s2_last_r;
  logic [10:0]     s2_pos_r;
  logic [9:0]      s2_nega_r, s2_negb_r;

  // output register
  logic             out_valid_r, out_last_r;
  logic [PIX_W-1:0] out_pix_r;

  logic        out_en, s2_free, s1_go, s1_free;
  logic [11:0] lap;
  logic [PIX_W-1:0] clamped;

  assign out_en  = !out_valid_r || out_ready;
  assign s2_free = !s2_valid_r || out_en;
  assign s1_go   = s1_valid_r && (!s1_item_r.emit || s2_free);
  assign s1_free = !s1_valid_r || s1_go;
  assign in_ready = s1_free;

  assign top = rdata[2*PIX_W-1:PIX_W];
  assign mid = rdata[PIX_W-1:0];

  always_comb begin
    win_nxt = win_r;
    if (s1_item_r.is_pix) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r][0] = win_r[r][1];
        win_nxt[r][1] = win_r[r][2];
      end
      win_nxt[0][2] = top;
      win_nxt[1][2] = mid;
      win_nxt[2][2] = s1_item_r.pix;
    end
  end

  // line store shifts down one line at this column
  assign ram_we    = s1_go && s1_item_r.is_pix;
  assign ram_waddr = s1_col_r;
  assign ram_wdata = {mid, s1_item_r.pix};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= accept;
    end
    if (s1_free && accept) begin
      s1_item_r <= item;
      s1_col_r  <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_go) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_go && s1_item_r.emit;
    end
    if (s2_free && s1_go) begin
      s2_border_r <= s1_item_r.border;
      s2_last_r   <= s1_item_r.last;
      s2_pos_r    <= {win_nxt[1][1], 3'b000};
      s2_nega_r   <= 10'(win_nxt[0][0]) + 10'(win_nxt[0][1]) +
                     10'(win_nxt[0][2]) + 10'(win_nxt[1][0]);
      s2_negb_r   <= 10'(win_nxt[1][2]) + 10'(win_nxt[2][0]) +
                     10'(win_nxt[2][1]) + 10'(win_nxt[2][2]);
    end
  end

  // signed sum, clamp to the pixel range
  always_comb begin
    lap = 12'(s2_pos_r) - 12'(s2_nega_r) - 12'(s2_negb_r);
    if (lap[11]) begin
      clamped = '0;
    end else if (lap > 12'(PIX_MAX)) begin
      clamped = PIX_MAX;
    end else begin
      clamped = lap[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s2_valid_r;
    end
    if (out_en && s2_valid_r) begin
      out_pix_r  <= s2_border_r ? PIX_MAX : clamped;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign pixel_out  = out_pix_r;
  assign frame_last = out_last_r;

endmodule
